// ----- hw/rtl/fbtm_pkg.sv -----
// ----------------------------------------------------------------------------
// fbtm_pkg
// types and constants for the fat12 bad track marker
// ----------------------------------------------------------------------------
package fbtm_pkg;

   // request codes
   localparam logic [1:0] REQ_MARK  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_UNUSABLE = 2'd1;
   localparam logic [1:0] STATUS_BEYOND   = 2'd2;

   // register indexes
   localparam int          CSR_IDX_W  = 3;
   localparam int          CSR_DATA_W = 16;
   localparam logic [2:0]  CSR_SPT    = 3'd0;
   localparam logic [2:0]  CSR_HEADS  = 3'd1;
   localparam logic [2:0]  CSR_SPC    = 3'd2;
   localparam logic [2:0]  CSR_SBYTES = 3'd3;
   localparam logic [2:0]  CSR_FDS    = 3'd4;

   // arithmetic widths
   localparam int SEC_W   = 28;                // track sector and dividend
   localparam int CL_W    = SEC_W + 1;         // cluster number
   localparam int OFF_W   = CL_W + 1;          // byte offset of a cluster
   localparam int ADD_W   = 19;                // bytes in one cluster
   localparam int SMALL_W = 9;                 // remainder plus track span
   localparam int CNT_W   = $clog2(SEC_W + 1);

   localparam logic [11:0] BAD_MARK    = 12'hFF7;
   localparam logic [11:0] CLUSTER_MAX = 12'hFFF;
   localparam logic [7:0]  KEEP_HI     = 8'hF0;
   localparam logic [7:0]  KEEP_LO     = 8'h0F;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [9:0]  cylinder;
      logic [7:0]  head;
      logic [12:0] table_address;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  read_data;
      logic [31:0] bad_bytes;
      logic [11:0] first_cluster;
      logic [11:0] last_cluster;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_CHECK,
      ST_DIV1,
      ST_DIV_MID,
      ST_DIV2,
      ST_RANGE,
      ST_MARK_A,
      ST_MARK_B,
      ST_READ,
      ST_CLEAR,
      ST_FINISH
   } fsm_state_type;

endpackage

// ----- hw/rtl/fat12_bad_track_marker_top.sv -----
// ----------------------------------------------------------------------------
// fat12_bad_track_marker_top
// packed fat12 allocation table in byte memory with bad track marking
// ----------------------------------------------------------------------------
// req channel (valid/ready) takes one request per transfer: mark a bad track,
// read one table byte, or clear the table and the bad byte total. every
// request gives exactly one transfer on the rsp channel (valid/ready).
// one request is worked at a time; req_ready is high only while idle.
// steps from req transfer to rsp valid:
//   read    one registered table read
//   clear   one table byte written per cycle over the whole table
//   mark    two multiplies and a check, then the bit serial divider
//           (28 + 9 steps), then per cluster in the table one read and
//           two writes on the byte memory (one read and one write per cycle)
//   unusable disk reply right after the check
// after reset the table is cleared by a pass over every byte, during
// which req_ready stays low; csr writes are taken at any time.
// a finished result sits in the rsp register until taken; a new request is
// accepted meanwhile, and the next result waits until the register frees.
// ----------------------------------------------------------------------------
module fat12_bad_track_marker_top #(
   parameter int TABLE_BYTES = 8192
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  fbtm_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output fbtm_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [fbtm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fbtm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(TABLE_BYTES);

   // configuration
   logic [7:0]  spt_ff, heads_ff, spc_ff;
   logic [10:0] sbytes_ff;
   logic [15:0] fds_ff;

   // control and datapath
   fbtm_pkg::fsm_state_type state_ff, state_in;
   fbtm_pkg::req_payload_type req_ff, req_in;
   logic [fbtm_pkg::SEC_W-1:0] sec_ff, sec_in;
   logic [fbtm_pkg::SEC_W-1:0] dq_ff, dq_in;
   logic [7:0]                 rem_ff, rem_in;
   logic [fbtm_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [fbtm_pkg::CL_W-1:0]  cl_ff, cl_in;
   logic [fbtm_pkg::CL_W-1:0]  ec_ff, ec_in;
   logic [fbtm_pkg::ADD_W-1:0] add_ff, add_in;
   logic [31:0]                total_ff, total_in;
   logic [1:0]                 status_ff, status_in;
   logic [7:0]                 rdata_ff, rdata_in;
   logic [11:0]                fc_ff, fc_in, lc_ff, lc_in;
   logic [AW-1:0]              clr_ff, clr_in;
   logic [AW-1:0]              mark_addr_ff, mark_addr_in;
   logic                       odd_ff, odd_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   fbtm_pkg::rsp_payload_type  rsp_ff, rsp_in;

   // memory
   logic [7:0]    alloc_mem [TABLE_BYTES];
   logic [7:0]    mem_rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata;

   // helpers
   logic [7:0]                   spt_eff, spc_eff;
   logic [18:0]                  mul2_a;
   logic [8:0]                   trial;
   logic                         ge;
   logic [7:0]                   rem_next;
   logic [fbtm_pkg::SEC_W-1:0]   dq_next;
   logic [fbtm_pkg::SMALL_W-1:0] small_dvd;
   logic [fbtm_pkg::OFF_W-1:0]   off, off_p1;
   logic                         off_ok;
   logic [32:0]                  sum;
   logic [31:0]                  addr_wide;

   assign spt_eff   = (spt_ff == 8'd0) ? 8'd1 : spt_ff;
   assign spc_eff   = (spc_ff == 8'd0) ? 8'd1 : spc_ff;
   assign mul2_a    = 19'(sec_ff) + 19'(req_ff.head);
   assign trial     = {rem_ff, dq_ff[fbtm_pkg::SEC_W-1]};
   assign ge        = trial >= {1'b0, spc_eff};
   assign rem_next  = ge ? 8'(trial - {1'b0, spc_eff}) : trial[7:0];
   assign dq_next   = {dq_ff[fbtm_pkg::SEC_W-2:0], ge};
   assign small_dvd = fbtm_pkg::SMALL_W'(rem_ff) + fbtm_pkg::SMALL_W'(spt_eff)
                      - fbtm_pkg::SMALL_W'(1);
   assign off       = fbtm_pkg::OFF_W'(cl_ff) + fbtm_pkg::OFF_W'(cl_ff >> 1);
   assign off_p1    = off + fbtm_pkg::OFF_W'(1);
   assign off_ok    = (fbtm_pkg::OFF_W + 1)'(off_p1) < (fbtm_pkg::OFF_W + 1)'(TABLE_BYTES);
   assign sum       = 33'(total_ff) + 33'(add_ff);
   assign addr_wide = 32'(req_payload.table_address);

   assign req_ready   = (state_ff == fbtm_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff    <= 8'd8;
         heads_ff  <= 8'd1;
         spc_ff    <= 8'd4;
         sbytes_ff <= 11'd512;
         fds_ff    <= 16'd32;
      end else if (csr_wr_en) begin
         case (csr_index)
            fbtm_pkg::CSR_SPT:    spt_ff    <= csr_wdata[7:0];
            fbtm_pkg::CSR_HEADS:  heads_ff  <= csr_wdata[7:0];
            fbtm_pkg::CSR_SPC:    spc_ff    <= csr_wdata[7:0];
            fbtm_pkg::CSR_SBYTES: sbytes_ff <= csr_wdata[10:0];
            fbtm_pkg::CSR_FDS:    fds_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // allocation table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         alloc_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= alloc_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbtm_pkg::ST_INIT;
         clr_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      sec_ff       <= sec_in;
      dq_ff        <= dq_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      cl_ff        <= cl_in;
      ec_ff        <= ec_in;
      add_ff       <= add_in;
      status_ff    <= status_in;
      rdata_ff     <= rdata_in;
      fc_ff        <= fc_in;
      lc_ff        <= lc_in;
      mark_addr_ff <= mark_addr_in;
      odd_ff       <= odd_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      sec_in       = sec_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      cl_in        = cl_ff;
      ec_in        = ec_ff;
      add_in       = add_ff;
      total_in     = total_ff;
      status_in    = status_ff;
      rdata_in     = rdata_ff;
      fc_in        = fc_ff;
      lc_in        = lc_ff;
      clr_in       = clr_ff;
      mark_addr_in = mark_addr_ff;
      odd_in       = odd_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = 8'h00;
      mem_raddr    = addr_wide[AW-1:0];

      case (state_ff)
         fbtm_pkg::ST_INIT: begin
            mem_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(TABLE_BYTES - 1)) begin
               clr_in   = '0;
               state_in = fbtm_pkg::ST_IDLE;
            end
         end
         fbtm_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_payload;
               status_in = fbtm_pkg::STATUS_OK;
               rdata_in  = 8'h00;
               fc_in     = 12'd0;
               lc_in     = 12'd0;
               case (req_payload.req_type)
                  fbtm_pkg::REQ_MARK:  state_in = fbtm_pkg::ST_MUL1;
                  fbtm_pkg::REQ_READ:  state_in = fbtm_pkg::ST_READ;
                  fbtm_pkg::REQ_CLEAR: state_in = fbtm_pkg::ST_CLEAR;
                  default:             state_in = fbtm_pkg::ST_FINISH;
               endcase
            end
         end
         fbtm_pkg::ST_MUL1: begin
            sec_in   = fbtm_pkg::SEC_W'(req_ff.cylinder * heads_ff);
            add_in   = fbtm_pkg::ADD_W'(spc_eff * sbytes_ff);
            state_in = fbtm_pkg::ST_MUL2;
         end
         fbtm_pkg::ST_MUL2: begin
            sec_in   = fbtm_pkg::SEC_W'(mul2_a * spt_eff);
            state_in = fbtm_pkg::ST_CHECK;
         end
         fbtm_pkg::ST_CHECK: begin
            if (sec_ff < fbtm_pkg::SEC_W'(fds_ff)) begin
               status_in = fbtm_pkg::STATUS_UNUSABLE;
               state_in  = fbtm_pkg::ST_FINISH;
            end else begin
               dq_in    = sec_ff - fbtm_pkg::SEC_W'(fds_ff);
               rem_in   = 8'd0;
               cnt_in   = fbtm_pkg::CNT_W'(fbtm_pkg::SEC_W);
               state_in = fbtm_pkg::ST_DIV1;
            end
         end
         fbtm_pkg::ST_DIV1, fbtm_pkg::ST_DIV2: begin
            dq_in  = dq_next;
            rem_in = rem_next;
            cnt_in = cnt_ff - fbtm_pkg::CNT_W'(1);
            if (cnt_ff == fbtm_pkg::CNT_W'(1)) begin
               state_in = (state_ff == fbtm_pkg::ST_DIV1) ? fbtm_pkg::ST_DIV_MID
                                                          : fbtm_pkg::ST_RANGE;
            end
         end
         fbtm_pkg::ST_DIV_MID: begin
            // first cluster = quotient + 2; last cluster offset = (remainder + track span) / cluster size
            cl_in    = fbtm_pkg::CL_W'(dq_ff) + fbtm_pkg::CL_W'(2);
            dq_in    = {small_dvd, (fbtm_pkg::SEC_W - fbtm_pkg::SMALL_W)'(0)};
            rem_in   = 8'd0;
            cnt_in   = fbtm_pkg::CNT_W'(fbtm_pkg::SMALL_W);
            state_in = fbtm_pkg::ST_DIV2;
         end
         fbtm_pkg::ST_RANGE: begin
            ec_in = cl_ff + fbtm_pkg::CL_W'(dq_ff);
            fc_in = (cl_ff > fbtm_pkg::CL_W'(fbtm_pkg::CLUSTER_MAX))
                    ? fbtm_pkg::CLUSTER_MAX : cl_ff[11:0];
            lc_in = ((cl_ff + fbtm_pkg::CL_W'(dq_ff)) > fbtm_pkg::CL_W'(fbtm_pkg::CLUSTER_MAX))
                    ? fbtm_pkg::CLUSTER_MAX : 12'(cl_ff + fbtm_pkg::CL_W'(dq_ff));
            state_in = fbtm_pkg::ST_MARK_A;
         end
         fbtm_pkg::ST_MARK_A: begin
            if (cl_ff > ec_ff) begin
               state_in = fbtm_pkg::ST_FINISH;
            end else if (!off_ok) begin
               status_in = fbtm_pkg::STATUS_BEYOND;
               cl_in     = cl_ff + fbtm_pkg::CL_W'(1);
            end else begin
               // the byte holding only mark bits is written now,
               // the shared byte is read here and merged next cycle
               mem_we = 1'b1;
               odd_in = cl_ff[0];
               if (cl_ff[0]) begin
                  mem_raddr    = off[AW-1:0];
                  mark_addr_in = off[AW-1:0];
                  mem_waddr    = off_p1[AW-1:0];
                  mem_wdata    = fbtm_pkg::BAD_MARK[11:4];
               end else begin
                  mem_raddr    = off_p1[AW-1:0];
                  mark_addr_in = off_p1[AW-1:0];
                  mem_waddr    = off[AW-1:0];
                  mem_wdata    = fbtm_pkg::BAD_MARK[7:0];
               end
               state_in = fbtm_pkg::ST_MARK_B;
            end
         end
         fbtm_pkg::ST_MARK_B: begin
            mem_we    = 1'b1;
            mem_waddr = mark_addr_ff;
            if (odd_ff) begin
               mem_wdata = (mem_rdata_ff & fbtm_pkg::KEEP_LO) | {fbtm_pkg::BAD_MARK[3:0], 4'h0};
            end else begin
               mem_wdata = (mem_rdata_ff & fbtm_pkg::KEEP_HI) | {4'h0, fbtm_pkg::BAD_MARK[11:8]};
            end
            total_in = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            cl_in    = cl_ff + fbtm_pkg::CL_W'(1);
            state_in = fbtm_pkg::ST_MARK_A;
         end
         fbtm_pkg::ST_READ: begin
            if (32'(req_ff.table_address) < 32'(TABLE_BYTES)) begin
               rdata_in = mem_rdata_ff;
            end
            state_in = fbtm_pkg::ST_FINISH;
         end
         fbtm_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(TABLE_BYTES - 1)) begin
               clr_in   = '0;
               total_in = '0;
               state_in = fbtm_pkg::ST_FINISH;
            end
         end
         fbtm_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status        = status_ff;
               rsp_in.read_data     = rdata_ff;
               rsp_in.bad_bytes     = total_ff;
               rsp_in.first_cluster = fc_ff;
               rsp_in.last_cluster  = lc_ff;
               rsp_valid_in         = 1'b1;
               state_in             = fbtm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fbtm_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_merge_addr : assert property (@(posedge clock) disable iff (reset)
      (state_ff == fbtm_pkg::ST_MARK_B) |-> (mem_waddr == $past(mem_raddr)))
      else $error("merge write does not hit the byte just read");

   a_write_in_table : assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (32'(mem_waddr) < 32'(TABLE_BYTES)))
      else $error("table write outside the table");

   a_total_grows : assert property (@(posedge clock) disable iff (reset)
      (state_ff == fbtm_pkg::ST_MARK_B) |=> (total_ff >= $past(total_ff)))
      else $error("bad byte total went down while marking");

   a_cluster_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == fbtm_pkg::ST_MARK_B) |-> (cl_ff <= ec_ff))
      else $error("marking past the last cluster");

   a_rsp_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (state_ff != fbtm_pkg::ST_IDLE ||
                                        $past(state_ff) != fbtm_pkg::ST_FINISH))
      else $error("result loaded over a waiting result");
`endif

endmodule
